[hdl/qbtsb_pkg.sv]
// Shared types and constants of the quad batch texture slot binder.
package qbtsb_pkg;

  localparam logic [1:0] REQ_FLAT  = 2'd0;
  localparam logic [1:0] REQ_TEX   = 2'd1;
  localparam logic [1:0] REQ_BEGIN = 2'd2;
  localparam logic [1:0] REQ_FLUSH = 2'd3;

  localparam logic [1:0] KIND_QUAD = 2'd0;
  localparam logic [1:0] KIND_BIND = 2'd1;
  localparam logic [1:0] KIND_DRAW = 2'd2;

  localparam logic [0:0] REG_LIMIT = 1'b0;
  localparam logic [0:0] REG_WHITE = 1'b1;

  localparam logic [15:0] LIMIT_RESET = 16'd20000;

  // slots_used for the largest slot count (32) fits in six bits
  localparam int USED_W = 6;

  typedef struct packed {
    logic              do_flush;
    logic              has_quad;
    logic              bank;
    logic [15:0]       flush_quads;
    logic [USED_W-1:0] flush_used;
    logic [3:0]        quad_slot;
    logic [17:0]       quad_voff;
  } cmd_t;

endpackage

[hdl/qbtsb_fifo.sv]
// Command queue between the front and back parts.
module qbtsb_fifo
  import qbtsb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));
  assign head_cmd = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

endmodule

[hdl/qbtsb_front.sv]
// Front part: accepts requests, finds texture slots, keeps the batch state.
module qbtsb_front
  import qbtsb_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [15:0]                limit,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic [15:0]                in_texture_id,
  input  logic                       q_full,
  output logic                       q_push,
  output cmd_t                       q_cmd,
  input  logic                       rd_bank,
  input  logic [$clog2(SLOTS)-1:0]   rd_idx,
  output logic [15:0]                rd_data,
  input  logic                       bind_done
);

  localparam int SW = $clog2(SLOTS);
  localparam int UW = $clog2(SLOTS + 1);

  logic [15:0]   tab_r [2][SLOTS];
  logic [UW-1:0] used_r, used_nxt;
  logic [15:0]   quads_r, quads_nxt;
  logic          bank_r, bank_nxt;
  logic          busy_r, busy_nxt;

  logic          is_quad, is_tex, lim_flush, full_flush, do_flush, accept;
  logic [15:0]   q0, q_place;
  logic [UW-1:0] u0;
  logic          hit_found;
  logic [SW-1:0] hit_slot, new_slot, slot_sel;
  logic          wr_en;

  assign rd_data = tab_r[rd_bank][rd_idx];

  assign is_quad   = (in_req_type == REQ_FLAT) || (in_req_type == REQ_TEX);
  assign is_tex    = (in_req_type == REQ_TEX);
  assign lim_flush = (quads_r >= limit);
  assign q0        = lim_flush ? '0 : quads_r;
  assign u0        = lim_flush ? UW'(1) : used_r;

  always_comb begin
    hit_found = 1'b0;
    hit_slot  = '0;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (tab_r[bank_r][i] == in_texture_id && UW'(i) < u0) begin
        hit_found = 1'b1;
        hit_slot  = SW'(i);
      end
    end
  end

  assign full_flush = is_tex && !hit_found && (u0 >= UW'(SLOTS));
  assign new_slot   = full_flush ? SW'(1) : SW'(u0);
  assign q_place    = full_flush ? '0 : q0;
  assign slot_sel   = !is_tex ? '0 : (hit_found ? hit_slot : new_slot);

  always_comb begin
    if (in_req_type == REQ_FLUSH) begin
      do_flush = (quads_r != '0);
    end else if (is_quad) begin
      do_flush = (lim_flush && quads_r != '0) || full_flush;
    end else begin
      do_flush = 1'b0;
    end
  end

  // a new flush waits until the back part has read the previous bank
  assign in_ready = !q_full && !(busy_r && do_flush);
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (do_flush || is_quad);
  assign wr_en    = accept && is_tex && !hit_found;

  always_comb begin
    q_cmd.do_flush    = do_flush;
    q_cmd.has_quad    = is_quad;
    q_cmd.bank        = bank_r;
    q_cmd.flush_quads = quads_r;
    q_cmd.flush_used  = USED_W'(used_r);
    q_cmd.quad_slot   = 4'(slot_sel);
    q_cmd.quad_voff   = {q_place, 2'b00};
  end

  always_comb begin
    used_nxt  = used_r;
    quads_nxt = quads_r;
    bank_nxt  = bank_r;
    busy_nxt  = busy_r && !bind_done;
    if (accept) begin
      if (is_quad) begin
        quads_nxt = q_place + 16'd1;
        if (is_tex && !hit_found) begin
          used_nxt = UW'(new_slot) + UW'(1);
        end else begin
          used_nxt = u0;
        end
      end else begin
        quads_nxt = '0;
        used_nxt  = UW'(1);
      end
      if (do_flush) begin
        bank_nxt = !bank_r;
        busy_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= UW'(1);
      quads_r <= '0;
      bank_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      quads_r <= quads_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tab_r[bank_nxt][new_slot] <= in_texture_id;
    end
  end

endmodule

[hdl/qbtsb_back.sv]
// Back part: turns queued commands into bind, draw and quad words.
module qbtsb_back
  import qbtsb_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [15:0]                white_id,
  input  logic                       q_empty,
  input  cmd_t                       q_head,
  output logic                       q_pop,
  output logic                       rd_bank,
  output logic [$clog2(SLOTS)-1:0]   rd_idx,
  input  logic [15:0]                rd_data,
  output logic                       bind_done,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_kind,
  output logic [3:0]                 out_slot,
  output logic [15:0]                out_bound_texture,
  output logic [17:0]                out_vertex_offset,
  output logic [18:0]                out_index_count,
  output logic                       out_last
);

  localparam int SW = $clog2(SLOTS);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_BIND = 4'b0010,
    PH_DRAW = 4'b0100,
    PH_QUAD = 4'b1000
  } phase_t;

  phase_t        ph_r, ph_nxt;
  cmd_t          cur_r, cur_nxt;
  logic [SW-1:0] idx_r, idx_nxt;

  logic          ov_r, ov_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [3:0]    slot_r, slot_nxt;
  logic [15:0]   bound_r, bound_nxt;
  logic [17:0]   voff_r, voff_nxt;
  logic [18:0]   icnt_r, icnt_nxt;
  logic          last_r, last_nxt;

  logic          can_emit, emit;

  assign can_emit = !ov_r || out_ready;
  assign rd_bank  = cur_r.bank;
  assign rd_idx   = idx_r;

  always_comb begin
    ph_nxt    = ph_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    bind_done = 1'b0;
    emit      = 1'b0;
    kind_nxt  = kind_r;
    slot_nxt  = slot_r;
    bound_nxt = bound_r;
    voff_nxt  = voff_r;
    icnt_nxt  = icnt_r;
    last_nxt  = last_r;
    if (can_emit) begin
      unique case (ph_r)
        PH_IDLE: begin
          if (!q_empty) begin
            q_pop = 1'b1;
            emit  = 1'b1;
            if (q_head.do_flush) begin
              cur_nxt   = q_head;
              idx_nxt   = SW'(1);
              ph_nxt    = PH_BIND;
              kind_nxt  = KIND_BIND;
              slot_nxt  = '0;
              bound_nxt = white_id;
              voff_nxt  = '0;
              icnt_nxt  = '0;
              last_nxt  = 1'b0;
            end else begin
              kind_nxt  = KIND_QUAD;
              slot_nxt  = q_head.quad_slot;
              bound_nxt = '0;
              voff_nxt  = q_head.quad_voff;
              icnt_nxt  = '0;
              last_nxt  = 1'b1;
            end
          end
        end
        PH_BIND: begin
          emit      = 1'b1;
          kind_nxt  = KIND_BIND;
          slot_nxt  = 4'(idx_r);
          bound_nxt = (USED_W'(idx_r) < cur_r.flush_used) ? rd_data : white_id;
          voff_nxt  = '0;
          icnt_nxt  = '0;
          last_nxt  = 1'b0;
          if (idx_r == SW'(SLOTS - 1)) begin
            ph_nxt    = PH_DRAW;
            bind_done = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        PH_DRAW: begin
          emit      = 1'b1;
          kind_nxt  = KIND_DRAW;
          slot_nxt  = '0;
          bound_nxt = '0;
          voff_nxt  = '0;
          icnt_nxt  = {1'b0, cur_r.flush_quads, 2'b00} + {2'b00, cur_r.flush_quads, 1'b0};
          last_nxt  = !cur_r.has_quad;
          ph_nxt    = cur_r.has_quad ? PH_QUAD : PH_IDLE;
        end
        PH_QUAD: begin
          emit      = 1'b1;
          kind_nxt  = KIND_QUAD;
          slot_nxt  = cur_r.quad_slot;
          bound_nxt = '0;
          voff_nxt  = cur_r.quad_voff;
          icnt_nxt  = '0;
          last_nxt  = 1'b1;
          ph_nxt    = PH_IDLE;
        end
        default: begin
          ph_nxt = PH_IDLE;
        end
      endcase
    end
    ov_nxt = emit ? 1'b1 : (ov_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    idx_r   <= idx_nxt;
    kind_r  <= kind_nxt;
    slot_r  <= slot_nxt;
    bound_r <= bound_nxt;
    voff_r  <= voff_nxt;
    icnt_r  <= icnt_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid         = ov_r;
  assign out_kind          = kind_r;
  assign out_slot          = slot_r;
  assign out_bound_texture = bound_r;
  assign out_vertex_offset = voff_r;
  assign out_index_count   = icnt_r;
  assign out_last          = last_r;

endmodule

[hdl/quad_batch_texture_slot_binder.sv]
// Top level of the quad batch texture slot binder.
// Quads that place without a flush are taken one per cycle while the queue has room and
// give one word each. A flush of a nonempty batch gives SLOTS bind words and one draw
// word, one word per cycle from the back sequencer unless the output stalls. The slot
// table is double banked: the front keeps taking quads into the new batch while the back
// reads the old bank, and a further flush is held until that bank read has finished.
// QUEUE_DEPTH commands sit between the front and back; the output word is registered.
module quad_batch_texture_slot_binder
  import qbtsb_pkg::*;
#(
  parameter int SLOTS       = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_texture_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_slot,
  output logic [15:0] out_bound_texture,
  output logic [17:0] out_vertex_offset,
  output logic [18:0] out_index_count,
  output logic        out_last
);

  localparam int SW = $clog2(SLOTS);

  logic [15:0]   limit_r, limit_nxt;
  logic [15:0]   white_r, white_nxt;

  logic          q_push, q_pop, q_empty, q_full;
  cmd_t          q_cmd, q_head;
  logic          rd_bank;
  logic [SW-1:0] rd_idx;
  logic [15:0]   rd_data;
  logic          bind_done;

  always_comb begin
    limit_nxt = limit_r;
    white_nxt = white_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LIMIT: limit_nxt = cfg_data;
        REG_WHITE: white_nxt = cfg_data;
        default:   limit_nxt = limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      white_r <= '0;
    end else begin
      limit_r <= limit_nxt;
      white_r <= white_nxt;
    end
  end

  qbtsb_front #(.SLOTS(SLOTS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .limit         (limit_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_texture_id (in_texture_id),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd),
    .rd_bank       (rd_bank),
    .rd_idx        (rd_idx),
    .rd_data       (rd_data),
    .bind_done     (bind_done)
  );

  qbtsb_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  qbtsb_back #(.SLOTS(SLOTS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .white_id          (white_r),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .rd_bank           (rd_bank),
    .rd_idx            (rd_idx),
    .rd_data           (rd_data),
    .bind_done         (bind_done),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_slot          (out_slot),
    .out_bound_texture (out_bound_texture),
    .out_vertex_offset (out_vertex_offset),
    .out_index_count   (out_index_count),
    .out_last          (out_last)
  );

endmodule

[verif/tb_quad_batch_texture_slot_binder.sv]
// Self-checking testbench of the quad batch texture slot binder: directed and random quads.
`timescale 1ns / 1ps

module tb_quad_batch_texture_slot_binder;
  import qbtsb_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 64;
  localparam int LONG_HOLD   = 200;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [15:0] tex;
    logic [17:0] voff;
    logic [18:0] icnt;
    logic        last;
  } bind_word_t;

  class slot_binder_score;
    bind_word_t  want_q[$];
    logic [15:0] quad_limit;
    logic [15:0] white_id;
    logic [15:0] slot_tex[SLOTS];
    int unsigned slots_used;
    int unsigned batch_quads;
    int          errors;

    function new();
      quad_limit  = LIMIT_RESET;
      white_id    = '0;
      slots_used  = 1;
      batch_quads = 0;
      errors      = 0;
      foreach (slot_tex[k]) slot_tex[k] = '0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [15:0] val);
      if (idx == REG_LIMIT) begin
        quad_limit = val;
      end else begin
        white_id = val;
      end
    endfunction

    function void push_word(logic [1:0] kind, int unsigned slot, logic [15:0] tex,
                            int unsigned voff, int unsigned icnt);
      bind_word_t w;
      w.kind = kind;
      w.slot = slot[3:0];
      w.tex  = tex;
      w.voff = voff[17:0];
      w.icnt = icnt[18:0];
      w.last = 1'b0;
      want_q.push_back(w);
    endfunction

    function void close_batch();
      int unsigned i;
      logic [15:0] t;
      if (batch_quads != 0) begin
        for (i = 0; i < SLOTS; i++) begin
          t = (i != 0 && i < slots_used) ? slot_tex[i] : white_id;
          push_word(KIND_BIND, i, t, 0, 0);
        end
        push_word(KIND_DRAW, 0, '0, 0, batch_quads * 6);
      end
      batch_quads = 0;
      slots_used  = 1;
    endfunction

    function void note_input(logic [1:0] req, logic [15:0] tex);
      int unsigned base;
      int unsigned slot;
      int unsigned i;
      bit          hit;
      base = want_q.size();
      if (req == REQ_BEGIN) begin
        batch_quads = 0;
        slots_used  = 1;
        return;
      end
      if (req == REQ_FLUSH) begin
        close_batch();
      end else begin
        if (batch_quads >= quad_limit) close_batch();
        slot = 0;
        if (req == REQ_TEX) begin
          hit = 1'b0;
          for (i = 1; i < slots_used && !hit; i++) begin
            if (slot_tex[i] == tex) begin
              slot = i;
              hit  = 1'b1;
            end
          end
          if (!hit) begin
            if (slots_used >= SLOTS) close_batch();
            slot = slots_used;
            slot_tex[slot] = tex;
            slots_used++;
          end
        end
        push_word(KIND_QUAD, slot, '0, batch_quads * 4, 0);
        batch_quads = (batch_quads + 1) & 16'hFFFF;
      end
      if (want_q.size() > base) want_q[want_q.size() - 1].last = 1'b1;
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch on %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_word(bind_word_t got);
      bind_word_t w;
      if (want_q.size() == 0) begin
        report("unexpected word, kind", got.kind, 0);
        return;
      end
      w = want_q.pop_front();
      if (got.kind !== w.kind) report("kind", got.kind, w.kind);
      if (got.slot !== w.slot) report("slot", got.slot, w.slot);
      if (got.tex  !== w.tex)  report("bound_texture", got.tex, w.tex);
      if (got.voff !== w.voff) report("vertex_offset", got.voff, w.voff);
      if (got.icnt !== w.icnt) report("index_count", got.icnt, w.icnt);
      if (got.last !== w.last) report("last", got.last, w.last);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_LIMIT;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = REQ_FLAT;
  logic [15:0] in_texture_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [3:0]  out_slot;
  logic [15:0] out_bound_texture;
  logic [17:0] out_vertex_offset;
  logic [18:0] out_index_count;
  logic        out_last;

  slot_binder_score sb = new();
  bit idle_on   = 1'b1;
  bit long_hold = 1'b0;
  int cycles    = 0;

  quad_batch_texture_slot_binder #(.SLOTS(SLOTS)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_texture_id    (in_texture_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_slot         (out_slot),
    .out_bound_texture(out_bound_texture),
    .out_vertex_offset(out_vertex_offset),
    .out_index_count  (out_index_count),
    .out_last         (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic send_word(logic [1:0] req, logic [15:0] tex);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_texture_id <= tex;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(req, tex);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] limit, logic [15:0] white);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    sb.write_reg(REG_LIMIT, limit);
    cfg_index <= REG_WHITE;
    cfg_data  <= white;
    @(posedge clk);
    sb.write_reg(REG_WHITE, white);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // span sets how many distinct ids the pool offers: small spans mostly match, large ones fill slots
  task automatic run_random(int count, int span, bit pause_mid);
    logic [15:0] pool[24];
    int          n;
    int          r;
    foreach (pool[k]) pool[k] = 16'($urandom);
    pool[0] = sb.white_id;
    for (n = 0; n < count; n++) begin
      if (pause_mid && n == count / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.want_q.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_word(REQ_TEX, pool[$urandom_range(0, span - 1)]);
      end else if (r < 75) begin
        send_word(REQ_FLAT, 16'($urandom));
      end else if (r < 83) begin
        send_word(REQ_TEX, 16'($urandom));
      end else if (r < 91) begin
        send_word(REQ_FLUSH, 16'($urandom));
      end else if (r < 95) begin
        send_word(REQ_BEGIN, 16'($urandom));
      end else begin
        send_word(2'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin : result_side
    bind_word_t got;
    int         hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        got = '{out_kind, out_slot, out_bound_texture, out_vertex_offset,
                out_index_count, out_last};
        sb.check_word(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) out_ready <= 1'b1;
      end else if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        hold_left = LONG_HOLD;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        hold_left = $urandom_range(1, 6);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : main_flow
    int k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small limit, white id at all ones
    set_regs(16'd3, 16'hFFFF);
    send_word(REQ_FLUSH, 16'h0000);
    send_word(REQ_FLAT, 16'hFFFF);
    send_word(REQ_TEX, 16'h0000);
    send_word(REQ_TEX, 16'hFFFF);
    send_word(REQ_TEX, 16'h0000);
    send_word(REQ_TEX, 16'h8001);
    send_word(REQ_BEGIN, 16'hFFFF);
    send_word(REQ_FLAT, 16'h0000);
    send_word(REQ_FLUSH, 16'hFFFF);
    send_word(REQ_FLUSH, 16'h0000);
    settle_idle();

    // fill every slot, then one more id
    set_regs(16'hFFFF, 16'h0000);
    send_word(REQ_BEGIN, 16'h5A5A);
    for (k = 0; k < 16; k++) send_word(REQ_TEX, 16'h0001 << k);
    send_word(REQ_FLUSH, 16'h0000);
    settle_idle();

    set_regs(16'd1, 16'($urandom));
    long_hold = 1'b1;
    run_random(85, 6, 1'b0);
    settle_idle();

    set_regs(16'd0, 16'hFFFF);
    run_random(85, 24, 1'b0);
    settle_idle();

    set_regs(16'hFFFF, 16'h0000);
    run_random(85, 24, 1'b1);
    settle_idle();

    set_regs(16'($urandom_range(2, 40)), 16'($urandom));
    run_random(85, 12, 1'b0);
    settle_idle();

    idle_on = 1'b0;
    set_regs(LIMIT_RESET, 16'($urandom));
    run_random(85, 24, 1'b0);
    settle_idle();

    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/qbtsb_pkg.sv
hdl/qbtsb_fifo.sv
hdl/qbtsb_front.sv
hdl/qbtsb_back.sv
hdl/quad_batch_texture_slot_binder.sv
verif/tb_quad_batch_texture_slot_binder.sv
